/* src/scs_pkg.sv */
// shared types, constants and helper functions of the segment cube slab tester
package scs_pkg;

   localparam int COORD_W   = 32;
   localparam int DIR_W     = 32;
   localparam int LEN_W     = 31;
   localparam int WIDE_W    = 66;
   localparam int QUO_W     = 31;
   localparam int REM_W     = 32;
   localparam int NUM_AXES  = 3;
   localparam int NUM_LANES = 2 * NUM_AXES;
   localparam int PREP_STAGES = 4;
   localparam int DIV_STAGES  = 8;
   localparam int DIV_STEPS   = QUO_W - 2;
   localparam int STEPS_PER_STAGE = (DIV_STEPS + DIV_STAGES - 1) / DIV_STAGES;
   localparam int CLIP_STAGES = 2;
   localparam int PIPE_DEPTH  = PREP_STAGES + DIV_STAGES + CLIP_STAGES;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_START_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_X   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Y   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Z   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SEG_LEN = 3'd6;

   typedef struct packed {
      logic signed [COORD_W-1:0] cube_x;
      logic signed [COORD_W-1:0] cube_y;
      logic signed [COORD_W-1:0] cube_z;
      logic        [LEN_W-1:0]   cube_side;
   } scs_req_type;

   typedef struct packed {
      logic             hit;
      logic [LEN_W-1:0] entry_distance;
   } scs_rsp_type;

   typedef struct packed {
      logic             ovf;
      logic             neg;
      logic [REM_W-1:0] den;
      logic [REM_W-1:0] rem;
      logic [QUO_W-1:0] quo;
   } scs_lane_type;

   typedef struct packed {
      logic dir_zero;
      logic in_slab;
   } scs_axis_type;

   function automatic logic signed [63:0] sat64(input logic signed [WIDE_W-1:0] v);
      if (v[WIDE_W-1:63] == '0 || v[WIDE_W-1:63] == '1) begin
         return v[63:0];
      end else if (v[WIDE_W-1]) begin
         return {1'b1, 63'd0};
      end else begin
         return {1'b0, {63{1'b1}}};
      end
   endfunction

endpackage

/* src/scs_prep.sv */
// per-axis front end: displacement, face numerators, magnitudes and first quotient bits
module scs_prep (
   input  logic                                clock,
   input  logic [scs_pkg::PREP_STAGES-1:0]     en,
   input  logic signed [scs_pkg::COORD_W-1:0]  centre,
   input  logic        [scs_pkg::LEN_W-1:0]    side,
   input  logic signed [scs_pkg::COORD_W-1:0]  start,
   input  logic signed [scs_pkg::DIR_W-1:0]    dir,
   output scs_pkg::scs_lane_type               lane_lo,
   output scs_pkg::scs_lane_type               lane_hi,
   output scs_pkg::scs_axis_type               axis
);
   import scs_pkg::*;

   logic signed [63:0]    disp_ff, disp_in;
   logic [LEN_W-1:0]      side1_ff;
   logic signed [63:0]    nlo_ff, nlo_in, nhi_ff, nhi_in;
   logic [63:0]           mlo_ff, mlo_in, mhi_ff, mhi_in;
   logic                  slo_ff, shi_ff, inside3_ff, inside_in;
   scs_lane_type          lane_lo_ff, lane_lo_in, lane_hi_ff, lane_hi_in;
   scs_axis_type          axis_ff, axis_in;
   logic signed [WIDE_W-1:0] c_w, s_w, d2_w, side_w;
   logic signed [63:0]    d2;
   logic [REM_W-1:0]      dmag;
   logic                  dneg;

   function automatic scs_lane_type first_bits(input logic [63:0] mag, input logic nsign,
                                               input logic [REM_W-1:0] den, input logic dsign);
      scs_lane_type     l;
      logic [33:0]      r;
      logic [33:0]      d1;
      logic             b1, b0;
      l.ovf = mag >= {30'd0, den, 2'b00};
      l.neg = nsign ^ dsign;
      l.den = den;
      r  = mag[33:0];
      d1 = {1'b0, den, 1'b0};
      b1 = r >= d1;
      if (b1) begin
         r = r - d1;
      end
      b0 = r >= {2'b00, den};
      if (b0) begin
         r = r - {2'b00, den};
      end
      l.rem = r[REM_W-1:0];
      l.quo = {{(QUO_W-2){1'b0}}, b1, b0};
      return l;
   endfunction

   assign c_w    = {{(WIDE_W-COORD_W){centre[COORD_W-1]}}, centre};
   assign s_w    = {{(WIDE_W-COORD_W){start[COORD_W-1]}}, start};
   assign disp_in = sat64(c_w - s_w);

   assign d2_w   = {disp_ff[63], disp_ff, 1'b0};
   assign d2     = sat64(d2_w);
   assign side_w = {{(WIDE_W-LEN_W){1'b0}}, side1_ff};
   assign nlo_in = sat64({{2{d2[63]}}, d2} - side_w);
   assign nhi_in = sat64({{2{d2[63]}}, d2} + side_w);

   assign mlo_in    = nlo_ff[63] ? 64'd0 - nlo_ff : nlo_ff;
   assign mhi_in    = nhi_ff[63] ? 64'd0 - nhi_ff : nhi_ff;
   assign inside_in = (nlo_ff[63] || nlo_ff == '0) && !nhi_ff[63];

   assign dneg       = dir[DIR_W-1];
   assign dmag       = dneg ? REM_W'(0) - REM_W'(dir) : REM_W'(dir);
   assign lane_lo_in = first_bits(mlo_ff, slo_ff, dmag, dneg);
   assign lane_hi_in = first_bits(mhi_ff, shi_ff, dmag, dneg);
   assign axis_in.dir_zero = dir == '0;
   assign axis_in.in_slab  = inside3_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         disp_ff  <= disp_in;
         side1_ff <= side;
      end
      if (en[1]) begin
         nlo_ff <= nlo_in;
         nhi_ff <= nhi_in;
      end
      if (en[2]) begin
         mlo_ff     <= mlo_in;
         mhi_ff     <= mhi_in;
         slo_ff     <= nlo_ff[63];
         shi_ff     <= nhi_ff[63];
         inside3_ff <= inside_in;
      end
      if (en[3]) begin
         lane_lo_ff <= lane_lo_in;
         lane_hi_ff <= lane_hi_in;
         axis_ff    <= axis_in;
      end
   end

   assign lane_lo = lane_lo_ff;
   assign lane_hi = lane_hi_ff;
   assign axis    = axis_ff;

endmodule

/* src/scs_div_stage.sv */
// one stage of the restoring dividers, STEPS quotient bits for every lane
module scs_div_stage #(
   parameter int STEPS = scs_pkg::STEPS_PER_STAGE
) (
   input  logic                                        clock,
   input  logic                                        en,
   input  scs_pkg::scs_lane_type [scs_pkg::NUM_LANES-1:0] lane_i,
   output scs_pkg::scs_lane_type [scs_pkg::NUM_LANES-1:0] lane_o
);
   import scs_pkg::*;

   scs_lane_type [NUM_LANES-1:0] lane_ff, lane_in;

   always_comb begin
      logic [REM_W:0] r2;
      for (int l = 0; l < NUM_LANES; l++) begin
         lane_in[l] = lane_i[l];
         for (int s = 0; s < STEPS; s++) begin
            r2 = {lane_in[l].rem, 1'b0};
            if (r2 >= {1'b0, lane_in[l].den}) begin
               r2 = r2 - {1'b0, lane_in[l].den};
               lane_in[l].quo = {lane_in[l].quo[QUO_W-2:0], 1'b1};
            end else begin
               lane_in[l].quo = {lane_in[l].quo[QUO_W-2:0], 1'b0};
            end
            lane_in[l].rem = r2[REM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_in;
      end
   end

   assign lane_o = lane_ff;

endmodule

/* src/scs_clip.sv */
// face parameter clamping, slab ordering and interval narrowing
module scs_clip (
   input  logic                                          clock,
   input  logic [scs_pkg::CLIP_STAGES-1:0]               en,
   input  scs_pkg::scs_lane_type [scs_pkg::NUM_LANES-1:0] lane,
   input  scs_pkg::scs_axis_type [scs_pkg::NUM_AXES-1:0]  axis,
   input  logic [scs_pkg::LEN_W-1:0]                     seg_length,
   output scs_pkg::scs_rsp_type                          rsp
);
   import scs_pkg::*;

   localparam int T_W = QUO_W + 2;

   logic signed [T_W-1:0] t0_ff [NUM_AXES];
   logic signed [T_W-1:0] t1_ff [NUM_AXES];
   logic signed [T_W-1:0] t0_in [NUM_AXES];
   logic signed [T_W-1:0] t1_in [NUM_AXES];
   scs_axis_type [NUM_AXES-1:0] axis_ff;
   scs_rsp_type  rsp_ff, rsp_in;

   function automatic logic signed [T_W-1:0] param_of(input scs_lane_type l);
      if (l.ovf) begin
         return l.neg ? -T_W'(1) : T_W'(1) << QUO_W;
      end else if (l.neg && l.quo != '0) begin
         return -T_W'(1);
      end else begin
         return {2'b00, l.quo};
      end
   endfunction

   always_comb begin
      logic signed [T_W-1:0] a, b;
      for (int x = 0; x < NUM_AXES; x++) begin
         a = param_of(lane[2*x]);
         b = param_of(lane[2*x+1]);
         if (a > b) begin
            t0_in[x] = b;
            t1_in[x] = a;
         end else begin
            t0_in[x] = a;
            t1_in[x] = b;
         end
      end
   end

   always_comb begin
      logic signed [T_W-1:0] lo, hi;
      logic ok;
      lo = '0;
      hi = {2'b00, seg_length};
      ok = 1'b1;
      for (int x = 0; x < NUM_AXES; x++) begin
         if (axis_ff[x].dir_zero) begin
            ok = ok & axis_ff[x].in_slab;
         end else begin
            if (t0_ff[x] > lo) begin
               lo = t0_ff[x];
            end
            if (t1_ff[x] < hi) begin
               hi = t1_ff[x];
            end
         end
      end
      rsp_in.hit = ok && lo <= hi;
      rsp_in.entry_distance = rsp_in.hit ? lo[LEN_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         t0_ff   <= t0_in;
         t1_ff   <= t1_in;
         axis_ff <= axis;
      end
      if (en[1]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

/* src/segment_cube_slab_intersect.sv */
// top level of the pipelined segment versus cube slab tester
//
// A segment is set through the csr port: start point (signed Q16.16), direction
// (signed Q2.30) and length (Q16.16). Write it only while no item is in flight.
// Each item on the req channel is a cube centre and full side; each gives exactly
// one rsp item with a hit flag and the entry distance along the segment (zero on
// a miss). Items are taken when req_valid is high and req_stall is low; results
// leave when rsp_valid is high and rsp_stall is low.
// From acceptance to rsp_valid an item passes four front-end stages,
// eight stages of the six restoring dividers (up to four quotient bits per stage)
// and two clipping stages. One item is accepted every cycle while req_stall is low.
// When the receiver stalls, the result holds in the output register and the
// stages behind it keep filling up bubbles; req_stall rises only once every
// stage holds an item. Reset empties the pipeline and clears all csr registers.
module segment_cube_slab_intersect (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  scs_pkg::scs_req_type             req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output scs_pkg::scs_rsp_type             rsp_payload,
   input  logic                             csr_we,
   input  logic [scs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [31:0]                      csr_wdata
);
   import scs_pkg::*;

   logic signed [COORD_W-1:0] start_ff [NUM_AXES];
   logic signed [DIR_W-1:0]   dir_ff   [NUM_AXES];
   logic [LEN_W-1:0]          seg_len_ff;
   logic [PIPE_DEPTH-1:0]     valid_ff, valid_in;
   logic [PIPE_DEPTH-1:0]     en;
   logic signed [COORD_W-1:0] centre [NUM_AXES];
   scs_lane_type [NUM_LANES-1:0] lanes [DIV_STAGES+1];
   scs_axis_type [NUM_AXES-1:0]  axis_p [DIV_STAGES+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff[0] <= '0;
         start_ff[1] <= '0;
         start_ff[2] <= '0;
         dir_ff[0]   <= '0;
         dir_ff[1]   <= '0;
         dir_ff[2]   <= '0;
         seg_len_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_START_X: start_ff[0] <= csr_wdata;
            CSR_START_Y: start_ff[1] <= csr_wdata;
            CSR_START_Z: start_ff[2] <= csr_wdata;
            CSR_DIR_X:   dir_ff[0]   <= csr_wdata;
            CSR_DIR_Y:   dir_ff[1]   <= csr_wdata;
            CSR_DIR_Z:   dir_ff[2]   <= csr_wdata;
            CSR_SEG_LEN: seg_len_ff  <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // a stage moves when it is empty or the one after it moves
   always_comb begin
      en[PIPE_DEPTH-1] = !valid_ff[PIPE_DEPTH-1] || !rsp_stall;
      for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
      valid_in[0] = req_valid;
      for (int k = 1; k < PIPE_DEPTH; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < PIPE_DEPTH; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = valid_ff[PIPE_DEPTH-1];

   assign centre[0] = req_payload.cube_x;
   assign centre[1] = req_payload.cube_y;
   assign centre[2] = req_payload.cube_z;

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
      scs_prep u_prep (
         .clock   (clock),
         .en      (en[PREP_STAGES-1:0]),
         .centre  (centre[a]),
         .side    (req_payload.cube_side),
         .start   (start_ff[a]),
         .dir     (dir_ff[a]),
         .lane_lo (lanes[0][2*a]),
         .lane_hi (lanes[0][2*a+1]),
         .axis    (axis_p[0][a])
      );
   end

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      localparam int LEFT  = DIV_STEPS - s * STEPS_PER_STAGE;
      localparam int STEPS = LEFT < STEPS_PER_STAGE ? LEFT : STEPS_PER_STAGE;

      scs_div_stage #(
         .STEPS (STEPS)
      ) u_div (
         .clock  (clock),
         .en     (en[PREP_STAGES+s]),
         .lane_i (lanes[s]),
         .lane_o (lanes[s+1])
      );

      always_ff @(posedge clock) begin
         if (en[PREP_STAGES+s]) begin
            axis_p[s+1] <= axis_p[s];
         end
      end
   end

   scs_clip u_clip (
      .clock      (clock),
      .en         (en[PIPE_DEPTH-1:PIPE_DEPTH-CLIP_STAGES]),
      .lane       (lanes[DIV_STAGES]),
      .axis       (axis_p[DIV_STAGES]),
      .seg_length (seg_len_ff),
      .rsp        (rsp_payload)
   );

endmodule

/* src/scs_checker.sv */
// port-level checks of the slab tester and their binding to the top level
module scs_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input scs_pkg::scs_rsp_type rsp_payload
);
   import scs_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result item changed");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result item right after reset");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.hit |-> rsp_payload.entry_distance == '0)
      else $error("miss with nonzero entry distance");

   a_no_stall_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with free output stage");

endmodule

bind segment_cube_slab_intersect scs_checker u_scs_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

/* bench/tb_segment_cube_slab_intersect.sv */
// testbench for the segment versus cube slab tester: directed and random cubes, checked by a predictor
module tb_segment_cube_slab_intersect;
   import scs_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   scs_req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   scs_rsp_type rsp_payload;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_START_X;
   logic [31:0] csr_wdata = '0;

   segment_cube_slab_intersect i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   localparam longint MAX64 = 64'sh7fff_ffff_ffff_ffff;
   localparam longint MIN64 = -64'sh7fff_ffff_ffff_ffff - 1;
   localparam longint QCAP = 64'sh4000_0000_0000_0000;
   localparam int CYCLE_LIMIT = 400000;

   logic signed [31:0] seg_start [3];
   logic signed [31:0] seg_dir [3];
   logic [30:0] seg_len;

   scs_rsp_type hit_queue [$];
   int mismatches = 0;
   int cycles = 0;
   int burst_left = 0;

   function automatic longint add_sat(longint a, longint b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > 65'(MAX64)) return MAX64;
      if (s < 65'(MIN64)) return MIN64;
      return longint'(s);
   endfunction

   function automatic longint sub_sat(longint a, longint b);
      logic signed [64:0] s;
      s = 65'(a) - 65'(b);
      if (s > 65'(MAX64)) return MAX64;
      if (s < 65'(MIN64)) return MIN64;
      return longint'(s);
   endfunction

   function automatic longint crossing(longint num, longint den);
      logic [63:0] n, d, qh, r, q;
      n = num < 0 ? 64'(-num) : 64'(num);
      d = den < 0 ? 64'(-den) : 64'(den);
      qh = n / d;
      r = n % d;
      if (qh >= (64'd1 << 33)) q = 64'(QCAP);
      else q = (qh << 29) + ((r << 29) / d);
      if (q > 64'(QCAP)) q = 64'(QCAP);
      return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
   endfunction

   function automatic scs_rsp_type predict_cube(scs_req_type c);
      scs_rsp_type res;
      longint lo, hi, disp, d2, nlo, nhi, t0, t1, tmp, side;
      logic signed [31:0] ctr [3];
      bit ok;
      ctr[0] = c.cube_x;
      ctr[1] = c.cube_y;
      ctr[2] = c.cube_z;
      side = longint'({33'd0, c.cube_side});
      lo = 0;
      hi = longint'({33'd0, seg_len});
      ok = 1;
      for (int a = 0; a < 3 && ok; a++) begin
         disp = sub_sat(longint'(ctr[a]), longint'(seg_start[a]));
         d2 = add_sat(disp, disp);
         nlo = sub_sat(d2, side);
         nhi = add_sat(d2, side);
         if (seg_dir[a] == 0) begin
            ok = (nlo <= 0) && (nhi >= 0);
         end else begin
            t0 = crossing(nlo, longint'(seg_dir[a]));
            t1 = crossing(nhi, longint'(seg_dir[a]));
            if (t0 > t1) begin
               tmp = t0; t0 = t1; t1 = tmp;
            end
            if (t0 > lo) lo = t0;
            if (t1 < hi) hi = t1;
            ok = lo <= hi;
         end
      end
      res.hit = ok;
      res.entry_distance = ok ? lo[30:0] : '0;
      return res;
   endfunction

   // result checker and receiver stall pattern
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (hit_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", rsp_payload);
         end else begin
            scs_rsp_type exp_r;
            exp_r = hit_queue.pop_front();
            if (exp_r.hit !== rsp_payload.hit ||
                exp_r.entry_distance !== rsp_payload.entry_distance) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected hit %0d dist %h, got hit %0d dist %h",
                           exp_r.hit, exp_r.entry_distance,
                           rsp_payload.hit, rsp_payload.entry_distance);
            end
         end
      end
   end

   always @(negedge clock) begin
      if ((cycles / 200) % 3 == 0) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 3) == 0);
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_START_X: seg_start[0] = val;
         CSR_START_Y: seg_start[1] = val;
         CSR_START_Z: seg_start[2] = val;
         CSR_DIR_X:   seg_dir[0] = val;
         CSR_DIR_Y:   seg_dir[1] = val;
         CSR_DIR_Z:   seg_dir[2] = val;
         CSR_SEG_LEN: seg_len = val[30:0];
         default: ;
      endcase
   endtask

   task automatic set_segment(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                              logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                              logic [31:0] len);
      write_reg(CSR_START_X, sx);
      write_reg(CSR_START_Y, sy);
      write_reg(CSR_START_Z, sz);
      write_reg(CSR_DIR_X, dx);
      write_reg(CSR_DIR_Y, dy);
      write_reg(CSR_DIR_Z, dz);
      write_reg(CSR_SEG_LEN, len);
   endtask

   // sender: called at a falling edge, returns at the falling edge after acceptance
   task automatic send_cube(scs_req_type c);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 4);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      req_valid <= 1'b1;
      req_payload <= c;
      do @(posedge clock); while (req_stall);
      hit_queue.push_back(predict_cube(c));
      burst_left--;
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      burst_left = 0;
      while (hit_queue.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   function automatic logic [31:0] rand_dir();
      int k;
      k = $urandom_range(0, 5);
      if (k == 0) return 32'd0;
      if (k == 1) return 32'h4000_0000;
      if (k == 2) return 32'hc000_0000;
      return 32'($signed($urandom_range(0, 32'h7fff_ffff)) - 32'sh4000_0000);
   endfunction

   function automatic scs_req_type near_cube();
      scs_req_type c;
      int r;
      r = $urandom_range(0, 9);
      c.cube_x = seg_start[0] + 32'($signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
      c.cube_y = seg_start[1] + 32'($signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
      c.cube_z = seg_start[2] + 32'($signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
      c.cube_side = 31'($urandom_range(0, 32'h01ff_ffff));
      if (r == 0) begin
         c.cube_x = $urandom;
         c.cube_y = $urandom;
         c.cube_z = $urandom;
         c.cube_side = 31'($urandom);
      end else if (r == 1) begin
         c.cube_side = 31'h7fff_ffff - 31'($urandom_range(0, 3));
      end
      return c;
   endfunction

   task automatic test_directed;
      scs_req_type c;
      set_segment(32'h0, 32'h0, 32'h0, 32'h4000_0000, 32'h0, 32'h0, 32'h000a_0000);
      c = '{32'h0005_0000, 32'h0, 32'h0, 31'h0002_0000}; send_cube(c);
      c = '{32'h0005_0000, 32'h0002_0000, 32'h0, 31'h0002_0000}; send_cube(c);
      c = '{32'h0005_0000, 32'h0001_0000, 32'h0, 31'h0002_0000}; send_cube(c);
      c = '{32'h000b_0000, 32'h0, 32'h0, 31'h0002_0000}; send_cube(c);
      c = '{32'hfff0_0000, 32'h0, 32'h0, 31'h0002_0000}; send_cube(c);
      c = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff}; send_cube(c);
      c = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff}; send_cube(c);
      c = '{32'h0, 32'h0, 32'h0, 31'h0}; send_cube(c);
      c = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 31'h0}; send_cube(c);
      drain();
      set_segment(32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hc000_0000, 32'h0000_0001,
                  32'h2d41_3ccd, 32'h7fff_ffff);
      c = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 31'h7fff_ffff}; send_cube(c);
      c = '{32'h7fff_0000, 32'h8000_0000, 32'h0001_0000, 31'h0004_0000}; send_cube(c);
      c = '{32'h0, 32'h0, 32'h0, 31'h7fff_ffff}; send_cube(c);
      c = '{32'h7fff_ffff, 32'h8000_0001, 32'h0, 31'h0}; send_cube(c);
      c = '{32'h7ffe_0000, 32'h8000_0000, 32'h0002_0000, 31'h0002_0000}; send_cube(c);
      drain();
   endtask

   task automatic test_random;
      for (int p = 0; p < 10; p++) begin
         if (p == 9) set_segment(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                                 32'h0, 32'h0, 32'h0, 32'h0);
         else set_segment($urandom, $urandom, $urandom, rand_dir(), rand_dir(),
                          rand_dir(), $urandom_range(0, 5) == 0 ? $urandom
                                      : $urandom_range(0, 32'h01ff_ffff));
         for (int i = 0; i < 103; i++) send_cube(near_cube());
         drain();
      end
   endtask

   initial begin
      foreach (seg_start[a]) begin
         seg_start[a] = '0;
         seg_dir[a] = '0;
      end
      seg_len = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random();
      if (mismatches == 0 && hit_queue.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
src/scs_pkg.sv
src/scs_prep.sv
src/scs_div_stage.sv
src/scs_clip.sv
src/segment_cube_slab_intersect.sv
src/scs_checker.sv
bench/tb_segment_cube_slab_intersect.sv
